FILE: rtl/dq_pkg.sv
// Shared types and constants for the double-ended queue.
// Command, status and cell operation codes, and the control word that is
// broadcast to every cell of the row. No dependencies.
package dq_pkg;

    localparam int WORD_W      = 32;
    localparam int DQ_DEPTH    = 1024;
    localparam int DQ_COUNT_W  = $clog2(DQ_DEPTH + 1);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    localparam logic signed [WORD_W-1:0] NONE_WORD = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY      = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    // Per-line operation: the front line holds the queue front-justified,
    // the back line holds it reversed and back-justified.
    typedef enum logic [1:0] {
        LN_HOLD      = 2'd0,
        LN_SHIFT_IN  = 2'd1,
        LN_SHIFT_OUT = 2'd2,
        LN_APPEND    = 2'd3
    } line_op_t;

    typedef enum logic [1:0] {
        OCC_HOLD   = 2'd0,
        OCC_GROW   = 2'd1,
        OCC_SHRINK = 2'd2
    } occ_op_t;

    typedef struct packed {
        line_op_t                  f_op;
        line_op_t                  b_op;
        occ_op_t                   occ_op;
        logic signed [WORD_W-1:0]  value;
    } cell_ctrl_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  popped;
    } op_info_t;

endpackage

FILE: rtl/dq_if.sv
// Request and result channel interfaces of the double-ended queue.
// Valid/ready handshake with payload; depends on dq_pkg.
interface dq_req_if;
    import dq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [WORD_W-1:0]  push_value;

    modport source (output valid, command, push_value, input ready);
    modport sink   (input valid, command, push_value, output ready);
endinterface

interface dq_rsp_if #(
    parameter int COUNT_W = dq_pkg::DQ_COUNT_W
);
    import dq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WORD_W-1:0]  popped_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  back_value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, popped_value, entry_count, is_empty, front_value,
                    back_value, status, input ready);
    modport sink   (input valid, popped_value, entry_count, is_empty, front_value,
                    back_value, status, output ready);
endinterface

FILE: rtl/double_ended_queue_top.sv
// Double-ended queue top level: a row of DEPTH cells plus decoder.
// The result is registered and valid in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; every cell
// shifts or writes in the same cycle, so no operation waits on a port.
// Reset: occupancy and count clear at once; stored words stay undefined.
// Depends on dq_pkg, dq_if, dq_ctrl and dq_cell.
module double_ended_queue_top #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    dq_req_if.sink        req,
    dq_rsp_if.source      rsp
);
    import dq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] f_word [DEPTH];
    logic signed [WORD_W-1:0] b_word [DEPTH];
    logic                     occ    [DEPTH];

    cell_ctrl_t cell_ctrl;
    op_info_t   info;
    logic       accept;
    logic       full;
    logic       empty;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic signed [WORD_W-1:0] popped_reg;
    status_t                  status_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign empty     = !occ[0];
    assign full      = occ[DEPTH-1];

    dq_ctrl u_ctrl (
        .accept     (accept),
        .command    (req.command),
        .push_value (req.push_value),
        .full       (full),
        .empty      (empty),
        .front_word (f_word[0]),
        .back_word  (b_word[0]),
        .cell_ctrl  (cell_ctrl),
        .info       (info)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] pf, pb, nf, nb;
        logic                     po, no;

        if (i == 0)
        begin : g_head
            assign pf = cell_ctrl.value;
            assign pb = cell_ctrl.value;
            assign po = 1'b1;
        end
        else
        begin : g_mid_prev
            assign pf = f_word[i-1];
            assign pb = b_word[i-1];
            assign po = occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign nf = '0;
            assign nb = '0;
            assign no = 1'b0;
        end
        else
        begin : g_mid_next
            assign nf = f_word[i+1];
            assign nb = b_word[i+1];
            assign no = occ[i+1];
        end

        dq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .prev_f   (pf),
            .prev_b   (pb),
            .prev_occ (po),
            .next_f   (nf),
            .next_b   (nb),
            .next_occ (no),
            .f_word   (f_word[i]),
            .b_word   (b_word[i]),
            .occ      (occ[i])
        );
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;

        count_next = count_reg;
        priority if (cell_ctrl.occ_op == OCC_GROW)
            count_next = count_reg + COUNT_W'(1);
        else if (cell_ctrl.occ_op == OCC_SHRINK)
            count_next = count_reg - COUNT_W'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    // Hold the per-request fields; the row itself holds front and back.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= info.popped;
            status_reg <= info.status;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.entry_count  = count_reg;
    assign rsp.is_empty     = !occ[0];
    assign rsp.front_value  = occ[0] ? f_word[0] : NONE_WORD;
    assign rsp.back_value   = occ[0] ? b_word[0] : NONE_WORD;
    assign rsp.status       = status_reg;

    a_head_occ_matches_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        occ[0] == (count_reg != '0)
    ) else $error("head occupancy disagrees with count");

    a_tail_occ_matches_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        occ[DEPTH-1] == (count_reg == COUNT_W'(DEPTH))
    ) else $error("tail occupancy disagrees with full count");

    a_grow_increments: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cell_ctrl.occ_op == OCC_GROW) |=> (count_reg == $past(count_reg) + COUNT_W'(1))
    ) else $error("count did not advance on push");

    a_full_status_means_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == ST_PUSH_FULL) |-> (count_reg == COUNT_W'(DEPTH))
    ) else $error("push dropped while queue not full");

endmodule

FILE: rtl/dq_cell.sv
// One storage cell of the queue row: a front-line word, a back-line word
// and an occupancy bit, updated from its two neighbors. Depends on dq_pkg.
module dq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dq_pkg::cell_ctrl_t                ctrl,
    input  logic signed [dq_pkg::WORD_W-1:0]  prev_f,
    input  logic signed [dq_pkg::WORD_W-1:0]  prev_b,
    input  logic                              prev_occ,
    input  logic signed [dq_pkg::WORD_W-1:0]  next_f,
    input  logic signed [dq_pkg::WORD_W-1:0]  next_b,
    input  logic                              next_occ,
    output logic signed [dq_pkg::WORD_W-1:0]  f_word,
    output logic signed [dq_pkg::WORD_W-1:0]  b_word,
    output logic                              occ
);
    import dq_pkg::*;

    logic signed [WORD_W-1:0] f_reg, f_next;
    logic signed [WORD_W-1:0] b_reg, b_next;
    logic                     occ_reg, occ_next;
    logic                     tail_slot;

    function automatic logic signed [WORD_W-1:0] line_next(
        input line_op_t                 op,
        input logic signed [WORD_W-1:0] cur,
        input logic signed [WORD_W-1:0] from_prev,
        input logic signed [WORD_W-1:0] from_next,
        input logic signed [WORD_W-1:0] value,
        input logic                     slot
    );
        logic signed [WORD_W-1:0] res;
        res = cur;
        unique case (op)
            LN_HOLD:      res = cur;
            LN_SHIFT_IN:  res = from_prev;
            LN_SHIFT_OUT: res = from_next;
            LN_APPEND:    res = slot ? value : cur;
        endcase
        return res;
    endfunction

    // First free cell of the row: the one an append lands in.
    assign tail_slot = prev_occ && !occ_reg;

    always_comb
    begin
        f_next = line_next(ctrl.f_op, f_reg, prev_f, next_f, ctrl.value, tail_slot);
        b_next = line_next(ctrl.b_op, b_reg, prev_b, next_b, ctrl.value, tail_slot);
    end

    always_comb
    begin
        unique case (ctrl.occ_op)
            OCC_GROW:   occ_next = prev_occ;
            OCC_SHRINK: occ_next = next_occ;
            default:    occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg <= f_next;
        b_reg <= b_next;
    end

    assign f_word = f_reg;
    assign b_word = b_reg;
    assign occ    = occ_reg;

endmodule

FILE: rtl/dq_ctrl.sv
// Command decoder: turns an accepted request into the control word for the
// cell row, the popped word and the status code. Depends on dq_pkg.
module dq_ctrl (
    input  logic                              accept,
    input  logic [dq_pkg::CMD_W-1:0]          command,
    input  logic signed [dq_pkg::WORD_W-1:0]  push_value,
    input  logic                              full,
    input  logic                              empty,
    input  logic signed [dq_pkg::WORD_W-1:0]  front_word,
    input  logic signed [dq_pkg::WORD_W-1:0]  back_word,
    output dq_pkg::cell_ctrl_t                cell_ctrl,
    output dq_pkg::op_info_t                  info
);
    import dq_pkg::*;

    always_comb
    begin
        cell_ctrl.f_op   = LN_HOLD;
        cell_ctrl.b_op   = LN_HOLD;
        cell_ctrl.occ_op = OCC_HOLD;
        cell_ctrl.value  = push_value;
        info.status      = ST_DONE;
        info.popped      = NONE_WORD;
        if (accept)
        begin
            unique case (cmd_t'(command))
                CMD_PUSH_FRONT:
                begin
                    if (full)
                        info.status = ST_PUSH_FULL;
                    else
                    begin
                        cell_ctrl.f_op   = LN_SHIFT_IN;
                        cell_ctrl.b_op   = LN_APPEND;
                        cell_ctrl.occ_op = OCC_GROW;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                        info.status = ST_PUSH_FULL;
                    else
                    begin
                        cell_ctrl.f_op   = LN_APPEND;
                        cell_ctrl.b_op   = LN_SHIFT_IN;
                        cell_ctrl.occ_op = OCC_GROW;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                        info.status = ST_POP_EMPTY;
                    else
                    begin
                        // back line drops its far end through occupancy alone
                        cell_ctrl.f_op   = LN_SHIFT_OUT;
                        cell_ctrl.occ_op = OCC_SHRINK;
                        info.popped      = front_word;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                        info.status = ST_POP_EMPTY;
                    else
                    begin
                        cell_ctrl.b_op   = LN_SHIFT_OUT;
                        cell_ctrl.occ_op = OCC_SHRINK;
                        info.popped      = back_word;
                    end
                end
                default:
                begin
                    // query and unused codes change nothing
                end
            endcase
        end
    end

endmodule

FILE: test/dq_result_checker.sv
// Result checker for the double-ended queue: predicts every result from the
// requests it sees taken and compares it field by field with the block's.
// Depends on dq_pkg and the dq_req_if / dq_rsp_if channel interfaces.
module dq_result_checker
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dq_req_if    req,
    dq_rsp_if    rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef struct {
        logic signed [WORD_W-1:0]  popped;
        logic [DQ_COUNT_W-1:0]     count;
        logic                      empty;
        logic signed [WORD_W-1:0]  front;
        logic signed [WORD_W-1:0]  back;
        status_t                   status;
    } deque_result_t;

    // Circular store mirrored from the block; only live slots are ever read.
    logic signed [WORD_W-1:0] held_words [DQ_DEPTH];
    int                       head_slot  = 0;
    int                       word_total = 0;
    deque_result_t            pending_results [$];

    function automatic deque_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [WORD_W-1:0] value);
        deque_result_t r;
        r.popped = NONE_WORD;
        r.status = ST_DONE;
        r.front  = NONE_WORD;
        r.back   = NONE_WORD;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK)
        begin
            if (word_total == DQ_DEPTH)
            begin
                r.status = ST_PUSH_FULL;
            end
            else if (cmd == CMD_PUSH_FRONT)
            begin
                head_slot = (head_slot + DQ_DEPTH - 1) % DQ_DEPTH;
                held_words[head_slot] = value;
                word_total++;
            end
            else
            begin
                held_words[(head_slot + word_total) % DQ_DEPTH] = value;
                word_total++;
            end
        end
        else if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK)
        begin
            if (word_total == 0)
            begin
                r.status = ST_POP_EMPTY;
            end
            else if (cmd == CMD_POP_FRONT)
            begin
                r.popped  = held_words[head_slot];
                head_slot = (head_slot + 1) % DQ_DEPTH;
                word_total--;
            end
            else
            begin
                r.popped = held_words[(head_slot + word_total - 1) % DQ_DEPTH];
                word_total--;
            end
        end
        // Spare command codes fall through as a plain query.
        if (word_total != 0)
        begin
            r.front = held_words[head_slot];
            r.back  = held_words[(head_slot + word_total - 1) % DQ_DEPTH];
        end
        r.count = word_total[DQ_COUNT_W-1:0];
        r.empty = (word_total == 0);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        deque_result_t want;
        if (rst_n)
        begin
            // Take the request first so a same-edge result still finds its entry.
            if (req.valid && req.ready)
                pending_results.insert(pending_results.size(),
                                       apply_command(req.command, req.push_value));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request waiting: popped_value 0x%08h",
                           rsp.popped_value);
                    mismatches++;
                end
                else
                begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    check_field("popped_value", want.popped, rsp.popped_value);
                    check_field("entry_count", WORD_W'(want.count), WORD_W'(rsp.entry_count));
                    check_field("is_empty", WORD_W'(want.empty), WORD_W'(rsp.is_empty));
                    check_field("front_value", want.front, rsp.front_value);
                    check_field("back_value", want.back, rsp.back_value);
                    check_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: test/double_ended_queue_top_tb.sv
// Testbench top for double_ended_queue_top: clock, reset, request stimulus
// and result back-pressure; dq_result_checker does the prediction and compare.
// Depends on dq_pkg, dq_if, the block and dq_result_checker.
module double_ended_queue_top_tb;
    import dq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    bit   src_calm = 1'b0;
    bit   snk_calm = 1'b0;
    int   stall_left = 0;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dq_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none at all while calm.
    function automatic int draw_gap(input bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_word();
        unique case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return NONE_WORD;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [WORD_W-1:0] value);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.push_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if ($urandom_range(0, 63) == 0)
            src_calm = !src_calm;
        gap = draw_gap(src_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_mixed(input int count);
        int roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 20)
                send_request(CMD_PUSH_FRONT, rand_word());
            else if (roll < 40)
                send_request(CMD_PUSH_BACK, rand_word());
            else if (roll < 60)
                send_request(CMD_POP_FRONT, rand_word());
            else if (roll < 80)
                send_request(CMD_POP_BACK, rand_word());
            else if (roll < 93)
                send_request(CMD_QUERY, rand_word());
            else
                send_request(CMD_SPARE_FIRST + CMD_W'($urandom_range(0, 2)), rand_word());
        end
    endtask

    // Lean toward one end: a run of pushes, or a run of pops that goes past empty.
    task automatic run_sweep(input bit filling, input int moves);
        int moved;
        moved = 0;
        while (moved < moves)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_request(CMD_QUERY, rand_word());
            end
            else
            begin
                if (filling)
                    send_request($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                 rand_word());
                else
                    send_request($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK,
                                 rand_word());
                moved++;
            end
        end
    endtask

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    snk_calm = !snk_calm;
                stall_left = draw_gap(snk_calm);
            end
        end
    end

    initial
    begin
        logic [CMD_W-1:0] spare;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_QUERY;
        req_ch.push_value = '0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: query and pops at both ends.
        send_request(CMD_QUERY, '0);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_BACK, NONE_WORD);
        // Push front from slot zero wraps the head downward.
        send_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(CMD_PUSH_BACK, 32'sh8000_0000);
        send_request(CMD_PUSH_FRONT, NONE_WORD);
        send_request(CMD_PUSH_BACK, '0);
        send_request(CMD_QUERY, 32'sh1234_5678);
        for (spare = CMD_SPARE_FIRST; spare != CMD_SPARE_LAST; spare++)
            send_request(spare, NONE_WORD);
        send_request(CMD_SPARE_LAST, NONE_WORD);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_BACK, '0);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_PUSH_BACK, 32'sh5555_5555);
        send_request(CMD_PUSH_BACK, 32'shAAAA_AAAA);
        send_request(CMD_POP_FRONT, '0);
        send_request(CMD_POP_FRONT, '0);

        run_mixed(250);
        run_sweep(1'b1, 200);
        run_sweep(1'b0, 230);
        run_mixed(230);

        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("double_ended_queue_top_tb: clean");
        else
            $display("double_ended_queue_top_tb: errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("double_ended_queue_top_tb: errors");
        $finish;
    end

endmodule

FILE: double_ended_queue_top.f
rtl/dq_pkg.sv
rtl/dq_if.sv
rtl/dq_cell.sv
rtl/dq_ctrl.sv
rtl/double_ended_queue_top.sv
test/dq_result_checker.sv
test/double_ended_queue_top_tb.sv
